FILE: hw/rtl/lms_pkg.sv
// ----------------------------------------------------------------------------
// lms_pkg
// Shared types and constants for the longest monotone subsequence tracker.
// ----------------------------------------------------------------------------
package lms_pkg;

   // width of every count field on the result channel
   localparam int FIELD_W = 11;
   // width of the key field on the request channel
   localparam int KEY_PORT_W = 32;

   typedef struct packed {
      logic start;
      logic strict_mode;
   } seek_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } seek_sts_type;

endpackage

FILE: hw/rtl/longest_monotone_subsequence.sv
// ----------------------------------------------------------------------------
// longest_monotone_subsequence
// Streaming longest increasing or non-decreasing subsequence tracker.
// ----------------------------------------------------------------------------
// Each key is placed, as in patience sorting, by binary search over a tail
// table held in two RAMs (smallest tail key per length, and that key's
// position). The search does one tail RAM read per cycle, and the longest
// table it sees holds DEPTH - 1 entries; then the slot is written and the
// result register is loaded. An item past DEPTH skips the search. Only one
// item is in flight; a new item may be taken while the last result waits on
// rsp_ready. The tail RAMs are not cleared: first only resets the counters.
// ----------------------------------------------------------------------------
module longest_monotone_subsequence #(
   parameter int DEPTH     = 1024,
   parameter int KEY_WIDTH = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [lms_pkg::KEY_PORT_W-1:0]    req_key,
   input  logic                                     req_first,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [lms_pkg::FIELD_W-1:0]              rsp_position,
   output logic [lms_pkg::FIELD_W-1:0]              rsp_length_here,
   output logic [lms_pkg::FIELD_W-1:0]              rsp_predecessor,
   output logic [lms_pkg::FIELD_W-1:0]              rsp_best_length,
   output logic [lms_pkg::FIELD_W-1:0]              rsp_best_end,
   output logic                                     rsp_overflow,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic                                     csr_strict_mode
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int FW     = lms_pkg::FIELD_W;
   localparam int KPW    = lms_pkg::KEY_PORT_W;
   localparam logic [KEY_WIDTH-1:0] KEY_SIGN = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_START = 4'b0010,
      ST_SEEK  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic                 strict_ff, strict_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [CNT_W-1:0]     alen_ff, alen_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     best_len_ff, best_len_in;
   logic [CNT_W-1:0]     best_end_ff, best_end_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     len_ff, len_in;
   logic [CNT_W-1:0]     pred_ff, pred_in;
   logic                 ovf_ff, ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]        rsp_position_ff, rsp_position_in;
   logic [FW-1:0]        rsp_length_here_ff, rsp_length_here_in;
   logic [FW-1:0]        rsp_predecessor_ff, rsp_predecessor_in;
   logic [FW-1:0]        rsp_best_length_ff, rsp_best_length_in;
   logic [FW-1:0]        rsp_best_end_ff, rsp_best_end_in;
   logic                 rsp_overflow_ff, rsp_overflow_in;

   logic [63:0]          key_ext;
   logic [KEY_WIDTH-1:0] key_biased;
   logic [CNT_W-1:0]     count_v;
   logic [CNT_W-1:0]     slot_len;
   logic                 req_accept;
   logic                 wr_en;

   lms_pkg::seek_ctl_type seek_ctl;
   lms_pkg::seek_sts_type seek_sts;
   logic [CNT_W-1:0]      seek_slot;
   logic [CNT_W-1:0]      seek_pred;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [KEY_WIDTH-1:0]  key_rdata;
   logic [CNT_W-1:0]      pos_rdata;

   // sign bit flipped so that unsigned compare gives signed order
   assign key_ext    = {{(64 - KPW){1'b0}}, req_key};
   assign key_biased = key_ext[KEY_WIDTH-1:0] ^ KEY_SIGN;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   assign seek_ctl.start       = (state_ff == ST_START);
   assign seek_ctl.strict_mode = strict_ff;

   always_comb begin
      state_in           = state_ff;
      strict_in          = strict_ff;
      key_in             = key_ff;
      alen_in            = alen_ff;
      count_in           = count_ff;
      best_len_in        = best_len_ff;
      best_end_in        = best_end_ff;
      pos_in             = pos_ff;
      len_in             = len_ff;
      pred_in            = pred_ff;
      ovf_in             = ovf_ff;
      rsp_valid_in       = rsp_valid_ff;
      rsp_position_in    = rsp_position_ff;
      rsp_length_here_in = rsp_length_here_ff;
      rsp_predecessor_in = rsp_predecessor_ff;
      rsp_best_length_in = rsp_best_length_ff;
      rsp_best_end_in    = rsp_best_end_ff;
      rsp_overflow_in    = rsp_overflow_ff;
      wr_en              = 1'b0;
      count_v            = req_first ? '0 : count_ff;
      slot_len           = seek_slot + CNT_W'(1);

      if (csr_valid) begin
         strict_in = csr_strict_mode;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               key_in = key_biased;
               if (req_first) begin
                  alen_in     = '0;
                  count_in    = '0;
                  best_len_in = '0;
                  best_end_in = '0;
               end
               if (count_v >= CNT_W'(DEPTH)) begin
                  // table full: item is dropped, state untouched
                  ovf_in   = 1'b1;
                  pos_in   = '0;
                  len_in   = '0;
                  pred_in  = '0;
                  state_in = ST_EMIT;
               end else begin
                  ovf_in   = 1'b0;
                  pos_in   = count_v + CNT_W'(1);
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            state_in = ST_SEEK;
         end
         ST_SEEK: begin
            if (seek_sts.done) begin
               wr_en    = 1'b1;
               if (seek_slot == alen_ff) begin
                  alen_in = alen_ff + CNT_W'(1);
               end
               count_in = pos_ff;
               len_in   = slot_len;
               pred_in  = seek_pred;
               // ties go to the later end position
               if (slot_len >= best_len_ff) begin
                  best_len_in = slot_len;
                  best_end_in = pos_ff;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_position_in    = FW'(pos_ff);
               rsp_length_here_in = FW'(len_ff);
               rsp_predecessor_in = FW'(pred_ff);
               rsp_best_length_in = FW'(best_len_ff);
               rsp_best_end_in    = FW'(best_end_ff);
               rsp_overflow_in    = ovf_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         strict_ff    <= 1'b1;
         alen_ff      <= '0;
         count_ff     <= '0;
         best_len_ff  <= '0;
         best_end_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         strict_ff    <= strict_in;
         alen_ff      <= alen_in;
         count_ff     <= count_in;
         best_len_ff  <= best_len_in;
         best_end_ff  <= best_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff             <= key_in;
      pos_ff             <= pos_in;
      len_ff             <= len_in;
      pred_ff            <= pred_in;
      ovf_ff             <= ovf_in;
      rsp_position_ff    <= rsp_position_in;
      rsp_length_here_ff <= rsp_length_here_in;
      rsp_predecessor_ff <= rsp_predecessor_in;
      rsp_best_length_ff <= rsp_best_length_in;
      rsp_best_end_ff    <= rsp_best_end_in;
      rsp_overflow_ff    <= rsp_overflow_in;
   end

   lms_seek #(
      .KEY_W  (KEY_WIDTH),
      .CNT_W  (CNT_W),
      .ADDR_W (ADDR_W)
   ) u_seek (
      .clock     (clock),
      .reset     (reset),
      .ctl       (seek_ctl),
      .key       (key_ff),
      .limit     (alen_ff),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .key_rdata (key_rdata),
      .pos_rdata (pos_rdata),
      .sts       (seek_sts),
      .slot      (seek_slot),
      .pred      (seek_pred)
   );

   lms_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (DEPTH)
   ) u_tail_keys (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (seek_slot[ADDR_W-1:0]),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (key_rdata)
   );

   lms_ram #(
      .WIDTH (CNT_W),
      .DEPTH (DEPTH)
   ) u_tail_positions (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (seek_slot[ADDR_W-1:0]),
      .wr_data (pos_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (pos_rdata)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_length_here = rsp_length_here_ff;
   assign rsp_predecessor = rsp_predecessor_ff;
   assign rsp_best_length = rsp_best_length_ff;
   assign rsp_best_end    = rsp_best_end_ff;
   assign rsp_overflow    = rsp_overflow_ff;

endmodule

FILE: hw/rtl/lms_ram.sv
// ----------------------------------------------------------------------------
// lms_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/lms_seek.sv
// ----------------------------------------------------------------------------
// lms_seek
// Binary search over the tail table: one tail read and one compare per cycle.
// Returns the first slot whose tail the key matches and the position stored
// one slot below it.
// ----------------------------------------------------------------------------
module lms_seek #(
   parameter int KEY_W  = 32,
   parameter int CNT_W  = 11,
   parameter int ADDR_W = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lms_pkg::seek_ctl_type ctl,
   input  logic [KEY_W-1:0]      key,
   input  logic [CNT_W-1:0]      limit,
   output logic                  rd_en,
   output logic [ADDR_W-1:0]     rd_addr,
   input  logic [KEY_W-1:0]      key_rdata,
   input  logic [CNT_W-1:0]      pos_rdata,
   output lms_pkg::seek_sts_type sts,
   output logic [CNT_W-1:0]      slot,
   output logic [CNT_W-1:0]      pred
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] pred_ff, pred_in;
   logic [CNT_W-1:0] span;
   logic             match;
   logic             active;
   logic             more;

   always_comb begin
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      pred_in = pred_ff;
      match   = 1'b0;
      if (ctl.start) begin
         lo_in   = '0;
         hi_in   = limit;
         pred_in = '0;
      end else if (busy_ff) begin
         // read data belongs to the slot at mid_ff, issued last cycle
         match = ctl.strict_mode ? (key <= key_rdata) : (key < key_rdata);
         if (match) begin
            hi_in = mid_ff;
         end else begin
            lo_in   = mid_ff + CNT_W'(1);
            pred_in = pos_rdata;
         end
      end
      span    = hi_in - lo_in;
      mid_in  = lo_in + (span >> 1);
      active  = ctl.start || busy_ff;
      more    = active && (lo_in < hi_in);
      busy_in = more;
      done_in = active && !(lo_in < hi_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      pred_ff <= pred_in;
   end

   assign rd_en    = more;
   assign rd_addr  = mid_in[ADDR_W-1:0];
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign slot     = lo_ff;
   assign pred     = pred_ff;

endmodule

FILE: hw/rtl/lms_checker.sv
// ----------------------------------------------------------------------------
// lms_checker
// Port-level checks for the longest monotone subsequence tracker.
// ----------------------------------------------------------------------------
module lms_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [lms_pkg::FIELD_W-1:0]           rsp_position,
   input logic [lms_pkg::FIELD_W-1:0]           rsp_length_here,
   input logic [lms_pkg::FIELD_W-1:0]           rsp_predecessor,
   input logic [lms_pkg::FIELD_W-1:0]           rsp_best_length,
   input logic [lms_pkg::FIELD_W-1:0]           rsp_best_end,
   input logic                                  rsp_overflow
);

   // dropped item carries no placement
   a_ovf_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         rsp_position == '0 && rsp_length_here == '0 && rsp_predecessor == '0)
      else $error("overflow item with nonzero placement");

   // predecessor precedes the item and the run length is bounded by the best
   a_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_overflow |->
         rsp_predecessor < rsp_position && rsp_length_here != '0 &&
         rsp_length_here <= rsp_best_length)
      else $error("inconsistent chain fields");

   // one item in flight
   a_single: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_position) && $stable(rsp_best_end))
      else $error("stalled result changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind longest_monotone_subsequence lms_checker u_lms_checker (.*);

FILE: tb/tb_longest_monotone_subsequence.sv
// ----------------------------------------------------------------------------
// tb_longest_monotone_subsequence
// Self-checking bench for the streaming longest monotone subsequence tracker.
// ----------------------------------------------------------------------------
// A short table of directed keys covers the key extremes, ties in both match
// modes and a stream that never raised first. A random phase of short
// sequences follows, then one sequence that fills the whole table and runs
// past it. Each result is compared with its typed row or with a patience-sort
// model kept in the bench. Both channels idle at random unless steady is set.
// ----------------------------------------------------------------------------
module tb_longest_monotone_subsequence;

   localparam int FW          = lms_pkg::FIELD_W;
   localparam int KPW         = lms_pkg::KEY_PORT_W;
   localparam int DEPTH       = 1024;
   localparam int STALL_LIMIT = 2000;
   localparam int SHORT_ITEMS = 30;
   localparam int KEY_MIN     = 32'sh8000_0000;
   localparam int KEY_MAX     = 32'sh7fff_ffff;
   localparam int KEY_STEP    = 4194304;  // 2**32 / DEPTH
   localparam bit MODE_NONDECR = 1'b0;
   localparam bit MODE_STRICT  = 1'b1;

   typedef struct packed {
      logic [FW-1:0] position;
      logic [FW-1:0] length_here;
      logic [FW-1:0] predecessor;
      logic [FW-1:0] best_length;
      logic [FW-1:0] best_end;
      logic          overflow;
   } placement_type;

   typedef enum logic {STEP_KEY, STEP_MODE} step_kind_type;
   typedef enum logic [1:0] {
      KEYS_NARROW, KEYS_WIDE, KEYS_RISING, KEYS_FALLING
   } key_style_type;

   typedef struct packed {
      step_kind_type kind;
      int            key;
      logic          first;
      logic          mode;
      logic          typed;
      placement_type want;
   } stim_row_type;

   localparam stim_row_type DIRECTED [27] = '{
      // no first after reset: starts from an empty table
      '{STEP_KEY,  5,       1'b0, MODE_STRICT,  1'b1, '{11'd1, 11'd1, 11'd0, 11'd1, 11'd1, 1'b0}},
      '{STEP_KEY,  5,       1'b0, MODE_STRICT,  1'b1, '{11'd2, 11'd1, 11'd0, 11'd1, 11'd2, 1'b0}},
      '{STEP_KEY,  KEY_MIN, 1'b0, MODE_STRICT,  1'b1, '{11'd3, 11'd1, 11'd0, 11'd1, 11'd3, 1'b0}},
      '{STEP_KEY,  KEY_MAX, 1'b0, MODE_STRICT,  1'b1, '{11'd4, 11'd2, 11'd3, 11'd2, 11'd4, 1'b0}},
      '{STEP_KEY,  KEY_MAX, 1'b0, MODE_STRICT,  1'b1, '{11'd5, 11'd2, 11'd3, 11'd2, 11'd5, 1'b0}},
      '{STEP_KEY,  -1,      1'b0, MODE_STRICT,  1'b0, '0},
      '{STEP_KEY,  0,       1'b1, MODE_STRICT,  1'b1, '{11'd1, 11'd1, 11'd0, 11'd1, 11'd1, 1'b0}},
      '{STEP_KEY,  1,       1'b0, MODE_STRICT,  1'b0, '0},
      '{STEP_KEY,  2,       1'b0, MODE_STRICT,  1'b0, '0},
      '{STEP_KEY,  3,       1'b0, MODE_STRICT,  1'b0, '0},
      '{STEP_KEY,  1,       1'b0, MODE_STRICT,  1'b0, '0},
      '{STEP_MODE, 0,       1'b0, MODE_NONDECR, 1'b0, '0},
      // equal keys extend the run in non-decreasing mode
      '{STEP_KEY,  7,       1'b1, MODE_NONDECR, 1'b1, '{11'd1, 11'd1, 11'd0, 11'd1, 11'd1, 1'b0}},
      '{STEP_KEY,  7,       1'b0, MODE_NONDECR, 1'b1, '{11'd2, 11'd2, 11'd1, 11'd2, 11'd2, 1'b0}},
      '{STEP_KEY,  7,       1'b0, MODE_NONDECR, 1'b1, '{11'd3, 11'd3, 11'd2, 11'd3, 11'd3, 1'b0}},
      '{STEP_KEY,  -1,      1'b0, MODE_NONDECR, 1'b0, '0},
      '{STEP_KEY,  KEY_MIN, 1'b0, MODE_NONDECR, 1'b0, '0},
      '{STEP_KEY,  KEY_MAX, 1'b0, MODE_NONDECR, 1'b0, '0},
      '{STEP_KEY,  KEY_MAX, 1'b0, MODE_NONDECR, 1'b0, '0},
      '{STEP_KEY,  0,       1'b0, MODE_NONDECR, 1'b0, '0},
      '{STEP_MODE, 0,       1'b0, MODE_STRICT,  1'b0, '0},
      '{STEP_KEY,  -5,      1'b1, MODE_STRICT,  1'b0, '0},
      '{STEP_KEY,  -6,      1'b0, MODE_STRICT,  1'b0, '0},
      '{STEP_KEY,  -7,      1'b0, MODE_STRICT,  1'b0, '0},
      '{STEP_KEY,  -7,      1'b0, MODE_STRICT,  1'b0, '0},
      '{STEP_KEY,  32'sh5555_5555, 1'b0, MODE_STRICT, 1'b0, '0},
      '{STEP_KEY,  32'shaaaa_aaaa, 1'b0, MODE_STRICT, 1'b0, '0}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [KPW-1:0]   req_key = '0;
   logic                    req_first = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [FW-1:0]           rsp_position;
   logic [FW-1:0]           rsp_length_here;
   logic [FW-1:0]           rsp_predecessor;
   logic [FW-1:0]           rsp_best_length;
   logic [FW-1:0]           rsp_best_end;
   logic                    rsp_overflow;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic                    csr_strict_mode = 1'b0;

   // patience piles: smallest top key per length and the position it came from
   int                 pile_top [DEPTH];
   logic [FW-1:0]      pile_pos [DEPTH];
   int unsigned        pile_count = 0;
   int unsigned        seq_len    = 0;
   int unsigned        top_len    = 0;
   int unsigned        top_end    = 0;
   bit                 strict_now = MODE_STRICT;

   placement_type      awaited_results [$];
   placement_type      got_r, want_r;
   bit                 steady = 1'b0;
   int                 idle_cycles = 0;
   int                 mismatches = 0;
   int                 results_checked = 0;
   int                 items_sent = 0;
   int                 overflow_items = 0;
   int                 mode_writes = 0;

   longest_monotone_subsequence #(
      .DEPTH    (DEPTH),
      .KEY_WIDTH(KPW)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_key        (req_key),
      .req_first      (req_first),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_position   (rsp_position),
      .rsp_length_here(rsp_length_here),
      .rsp_predecessor(rsp_predecessor),
      .rsp_best_length(rsp_best_length),
      .rsp_best_end   (rsp_best_end),
      .rsp_overflow   (rsp_overflow),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_strict_mode(csr_strict_mode)
   );

   always #5 clock = ~clock;

   // places one key on the piles and returns the result it should produce
   function automatic placement_type place_key(input int key, input bit first_flag);
      placement_type r;
      int unsigned   lo, hi, mid, slot;
      bit            hit;
      r = '0;
      if (first_flag) begin
         pile_count = 0;
         seq_len    = 0;
         top_len    = 0;
         top_end    = 0;
      end
      if (seq_len >= DEPTH) begin
         r.best_length = FW'(top_len);
         r.best_end    = FW'(top_end);
         r.overflow    = 1'b1;
         return r;
      end
      lo = 0;
      hi = pile_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         hit = strict_now ? (key <= pile_top[mid]) : (key < pile_top[mid]);
         if (hit) hi = mid;
         else lo = mid + 1;
      end
      slot = lo;
      if (slot == pile_count) pile_count++;
      seq_len        = seq_len + 1;
      pile_top[slot] = key;
      pile_pos[slot] = FW'(seq_len);
      r.predecessor  = (slot > 0) ? pile_pos[slot-1] : '0;
      if (slot + 1 >= top_len) begin  // ties go to the later end
         top_len = slot + 1;
         top_end = seq_len;
      end
      r.position    = FW'(seq_len);
      r.length_here = FW'(slot + 1);
      r.best_length = FW'(top_len);
      r.best_end    = FW'(top_end);
      return r;
   endfunction

   function automatic int spread_key(input key_style_type style, input int unsigned idx);
      longint v;
      if ($urandom_range(0, 29) == 0) return int'($urandom);
      case (style)
         KEYS_NARROW:  v = longint'($urandom_range(0, 16)) - 8;
         KEYS_WIDE:    v = longint'(int'($urandom));
         KEYS_RISING:  v = longint'(KEY_MIN) + longint'(idx % DEPTH) * KEY_STEP
                           + $urandom_range(0, KEY_STEP - 1);
         default:      v = longint'(KEY_MAX) - longint'(idx % DEPTH) * KEY_STEP
                           - $urandom_range(0, KEY_STEP - 1);
      endcase
      return int'(v);
   endfunction

   task automatic send_item(input int key, input bit first_flag,
                            input bit typed, input placement_type typed_want);
      placement_type predicted;
      while (!steady && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_key   <= key;
      req_first <= first_flag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = place_key(key, first_flag);
      awaited_results.push_back(typed ? typed_want : predicted);
      items_sent++;
      if (predicted.overflow) overflow_items++;
   endtask

   // hold the sender until every result is back
   task automatic settle();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_mode(input bit mode);
      csr_valid       <= 1'b1;
      csr_strict_mode <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      strict_now = mode;
      mode_writes++;
   endtask

   task automatic check_field(input string what, input int unsigned want, input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // result side: random stalls and compare against the oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         rsp_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 31);
         if (rsp_valid && rsp_ready) begin
            got_r = '{rsp_position, rsp_length_here, rsp_predecessor,
                      rsp_best_length, rsp_best_end, rsp_overflow};
            if (awaited_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result item, position %0d", $time, rsp_position);
            end else begin
               want_r = awaited_results.pop_front();
               results_checked++;
               check_field("position",    want_r.position,    got_r.position);
               check_field("length_here", want_r.length_here, got_r.length_here);
               check_field("predecessor", want_r.predecessor, got_r.predecessor);
               check_field("best_length", want_r.best_length, got_r.best_length);
               check_field("best_end",    want_r.best_end,    got_r.best_end);
               check_field("overflow",    want_r.overflow,    got_r.overflow);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned   short_items;
      int unsigned   seq_n;
      key_style_type style;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[r]) begin
         if (DIRECTED[r].kind == STEP_MODE) begin
            settle();
            write_mode(DIRECTED[r].mode);
         end else begin
            send_item(DIRECTED[r].key, DIRECTED[r].first, DIRECTED[r].typed, DIRECTED[r].want);
         end
      end

      // short sequences of mixed key styles, mode changed now and then
      short_items = 0;
      while (short_items < SHORT_ITEMS) begin
         if ($urandom_range(0, 4) == 0) begin
            settle();
            write_mode($urandom_range(0, 1));
         end
         seq_n = $urandom_range(1, 40);
         style = key_style_type'($urandom_range(0, 3));
         for (int unsigned i = 0; i < seq_n; i++) begin
            send_item(spread_key(style, i),
                      (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0),
                      1'b0, '0);
            short_items++;
         end
      end

      // one sequence that fills the table, then keys that must be refused
      settle();
      write_mode($urandom_range(0, 1));
      for (int unsigned i = 0; i < DEPTH + 6; i++) begin
         steady = (i < 300);
         send_item(spread_key((i < DEPTH) ? KEYS_RISING : KEYS_WIDE, i), (i == 0), 1'b0, '0);
      end

      settle();
      write_mode(!strict_now);
      for (int unsigned i = 0; i < 25; i++)
         send_item(spread_key(KEYS_NARROW, i), (i == 0), 1'b0, '0);

      settle();
      repeat (20) @(posedge clock);
      $display("Covered %0d keys in both match modes over %0d mode writes, %0d past a full table.",
               items_sent, mode_writes, overflow_items);
      $display("Compared %0d results, %0d mismatches.", results_checked, mismatches);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/lms_pkg.sv
hw/rtl/lms_ram.sv
hw/rtl/lms_seek.sv
hw/rtl/longest_monotone_subsequence.sv
hw/rtl/lms_checker.sv
tb/tb_longest_monotone_subsequence.sv
